/* hw/rtl/tbop_pkg.sv */
package tbop_pkg;

	// Event codes carried in the event_res field of each result item.
	typedef enum logic [4:0] {
		EV_NULL      = 5'd0,
		EV_TRUE      = 5'd1,
		EV_FALSE     = 5'd2,
		EV_TINY      = 5'd3,
		EV_I32       = 5'd4,
		EV_U32       = 5'd5,
		EV_I64       = 5'd6,
		EV_U64       = 5'd7,
		EV_F64       = 5'd8,
		EV_STRSTART  = 5'd9,
		EV_STRBYTE   = 5'd10,
		EV_LISTOPEN  = 5'd11,
		EV_DICTOPEN  = 5'd12,
		EV_EMPTYLIST = 5'd13,
		EV_EMPTYDICT = 5'd14,
		EV_BADTAG    = 5'd15,
		EV_TOODEEP   = 5'd16,
		EV_TRUNC     = 5'd17
	} ev_t;

	typedef enum logic [1:0] {
		PH_TAG,
		PH_OPERAND,
		PH_STRING,
		PH_IGNORE
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_CLOSE,
		ST_TRUNC
	} st_t;

	typedef enum logic [3:0] {
		K_NULL,
		K_TRUE,
		K_FALSE,
		K_STR,
		K_TINY,
		K_LIST,
		K_DICT,
		K_OPER,
		K_BAD
	} kind_t;

	typedef enum logic [2:0] {
		A_NONE,
		A_EMIT,
		A_PUSH,
		A_FAIL,
		A_COMPLETE
	} act_t;

	localparam logic [7:0] TAG_NULL   = 8'h60;
	localparam logic [7:0] TAG_TRUE   = 8'h61;
	localparam logic [7:0] TAG_FALSE  = 8'h62;
	localparam logic [7:0] TAG_F64    = 8'h63;
	localparam logic [7:0] TAG_I64    = 8'h64;
	localparam logic [7:0] TAG_U64    = 8'h65;
	localparam logic [7:0] TAG_STR32  = 8'h66;
	localparam logic [7:0] TAG_I32    = 8'h67;
	localparam logic [7:0] TAG_U32    = 8'h68;
	localparam logic [7:0] TAG_DICT32 = 8'h69;
	localparam logic [7:0] TAG_LIST32 = 8'h6A;

	localparam logic [7:0] MASK_CLS = 8'hE0;
	localparam logic [7:0] MASK_LOW = 8'h1F;
	localparam logic [7:0] CLS_STR  = 8'h80;
	localparam logic [7:0] CLS_TINY = 8'hC0;
	localparam logic [7:0] CLS_LIST = 8'h40;
	localparam logic [7:0] CLS_DICT = 8'h20;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		kind_t      kind;
	} qitem_t;

	// Declared from the top bit down, so event_res lands in the lowest bits.
	typedef struct packed {
		logic        object_done;
		logic [6:0]  closes;
		logic        is_key;
		logic [6:0]  nest_level;
		logic [63:0] payload;
		ev_t         event_res;
	} res_t;

	function automatic kind_t classify(input logic [7:0] b);
		kind_t k;
		priority if (b == TAG_NULL) k = K_NULL;
		else if (b == TAG_TRUE) k = K_TRUE;
		else if (b == TAG_FALSE) k = K_FALSE;
		else if ((b & MASK_CLS) == CLS_STR) k = K_STR;
		else if ((b & MASK_CLS) == CLS_TINY) k = K_TINY;
		else if ((b & MASK_CLS) == CLS_LIST) k = K_LIST;
		else if ((b & MASK_CLS) == CLS_DICT) k = K_DICT;
		else if (b == TAG_F64 || b == TAG_I64 || b == TAG_U64 || b == TAG_STR32 ||
			b == TAG_I32 || b == TAG_U32 || b == TAG_DICT32 || b == TAG_LIST32) k = K_OPER;
		else k = K_BAD;
		return k;
	endfunction

	function automatic logic [3:0] operand_size(input logic [7:0] b);
		logic [3:0] n;
		if (b == TAG_I32 || b == TAG_U32 || b == TAG_STR32 || b == TAG_LIST32 ||
			b == TAG_DICT32) n = 4'd4;
		else n = 4'd8;
		return n;
	endfunction

endpackage

/* hw/rtl/tbop_front.sv */
module tbop_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,
	input  logic                 s_axis_tlast,
	output logic                 q_valid,
	input  logic                 q_ready,
	output tbop_pkg::qitem_t     q_item
);

	tbop_pkg::qitem_t           fifo_q [tbop_pkg::QDEPTH];
	logic [tbop_pkg::QAW-1:0]   wr_ptr_q;
	logic [tbop_pkg::QAW-1:0]   rd_ptr_q;
	logic [tbop_pkg::QAW:0]     cnt_q;
	logic                       push;
	logic                       pop;

	assign s_axis_tready = cnt_q != (tbop_pkg::QAW+1)'(tbop_pkg::QDEPTH);
	assign q_valid       = cnt_q != '0;
	assign q_item        = fifo_q[rd_ptr_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_valid && q_ready;

	// The tag class is worked out on the way in, so the back end only looks it up.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{data: s_axis_tdata, last: s_axis_tlast,
				kind: tbop_pkg::classify(s_axis_tdata)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* hw/rtl/tbop_back.sv */
module tbop_back #(
	parameter int MAX_NEST = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  tbop_pkg::qitem_t     q_item,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [79:0]          m_axis_tdata,
	output logic [4:0]           m_axis_tuser,
	output logic                 m_axis_tlast
);

	localparam int LW = $clog2(MAX_NEST + 1);
	localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

	typedef struct packed {
		logic [31:0] rem;
		logic        dict;
		logic        key;
	} lvl_t;

	tbop_pkg::st_t     st_q, st_n;
	tbop_pkg::phase_t  phase_q, ph_b, ph_after;
	logic [7:0]        held_q;
	logic [3:0]        op_left_q;
	logic [2:0]        op_pos_q;
	logic [63:0]       acc_q, acc_ins;
	logic [31:0]       str_left_q;
	logic [LW-1:0]     open_q, open_n;
	lvl_t              top_q, rd_q;
	lvl_t              mem [MAX_NEST];
	logic [AW-1:0]     wr_addr, rd_addr;

	tbop_pkg::ev_t     p_ev_q;
	logic [63:0]       p_pay_q;
	logic [6:0]        p_nest_q, p_closes_q;
	logic              p_key_q, p_last_q;

	logic              out_vld_q, out_last_q;
	tbop_pkg::res_t    out_res_q, emit_res;
	logic              emit, emit_last;

	tbop_pkg::act_t    act;
	tbop_pkg::ev_t     ev;
	logic [63:0]       pay;
	logic              str_req, cont_req, cont_dict, start_op;
	logic [31:0]       str_len, cont_cnt, w, rem_dec;
	logic [7:0]        b;
	logic              out_free, take, key_pos, at_limit;
	logic              run_complete, close_step, step_en, step_pop, step_key, step_done;
	logic              step_stop, popping, byte_end, cur_last, do_reset, go_trunc, push_now;
	logic [6:0]        open7;

	assign b        = q_item.data;
	assign out_free = !out_vld_q || m_axis_tready;
	assign take     = (st_q == tbop_pkg::ST_RUN) && q_valid && out_free;
	assign q_ready  = take;
	assign key_pos  = (open_q != '0) && top_q.dict && !top_q.key;
	assign at_limit = open_q >= LW'(MAX_NEST);
	assign open7    = 7'(open_q);
	assign acc_ins  = acc_q | (64'(b) << {op_pos_q, 3'b000});
	assign w        = acc_ins[31:0];

	// Work out what the byte at the head of the queue does.
	always_comb begin
		act       = tbop_pkg::A_NONE;
		ev        = tbop_pkg::EV_NULL;
		pay       = '0;
		ph_b      = phase_q;
		str_req   = 1'b0;
		str_len   = '0;
		cont_req  = 1'b0;
		cont_dict = 1'b0;
		cont_cnt  = '0;
		start_op  = 1'b0;
		unique case (phase_q)
			tbop_pkg::PH_TAG: begin
				unique case (q_item.kind)
					tbop_pkg::K_NULL: begin
						act = tbop_pkg::A_COMPLETE;
						ev  = tbop_pkg::EV_NULL;
					end
					tbop_pkg::K_TRUE: begin
						act = tbop_pkg::A_COMPLETE;
						ev  = tbop_pkg::EV_TRUE;
					end
					tbop_pkg::K_FALSE: begin
						act = tbop_pkg::A_COMPLETE;
						ev  = tbop_pkg::EV_FALSE;
					end
					tbop_pkg::K_TINY: begin
						act = tbop_pkg::A_COMPLETE;
						ev  = tbop_pkg::EV_TINY;
						pay = 64'(b & tbop_pkg::MASK_LOW);
					end
					tbop_pkg::K_STR: begin
						str_req = 1'b1;
						str_len = 32'(b & tbop_pkg::MASK_LOW);
					end
					tbop_pkg::K_LIST: begin
						cont_req = 1'b1;
						cont_cnt = 32'(b & tbop_pkg::MASK_LOW);
					end
					tbop_pkg::K_DICT: begin
						cont_req  = 1'b1;
						cont_dict = 1'b1;
						cont_cnt  = 32'(b & tbop_pkg::MASK_LOW);
					end
					tbop_pkg::K_OPER: begin
						start_op = 1'b1;
						ph_b     = tbop_pkg::PH_OPERAND;
					end
					default: begin
						act = tbop_pkg::A_FAIL;
						ev  = tbop_pkg::EV_BADTAG;
						pay = 64'(b);
					end
				endcase
			end
			tbop_pkg::PH_OPERAND: begin
				if (op_left_q == 4'd1) begin
					unique case (held_q)
						tbop_pkg::TAG_STR32: begin
							str_req = 1'b1;
							str_len = w;
						end
						tbop_pkg::TAG_F64: begin
							act = tbop_pkg::A_COMPLETE;
							ev  = tbop_pkg::EV_F64;
							pay = acc_ins;
						end
						tbop_pkg::TAG_I64: begin
							act = tbop_pkg::A_COMPLETE;
							ev  = tbop_pkg::EV_I64;
							pay = acc_ins;
						end
						tbop_pkg::TAG_U64: begin
							act = tbop_pkg::A_COMPLETE;
							ev  = tbop_pkg::EV_U64;
							pay = acc_ins;
						end
						tbop_pkg::TAG_I32: begin
							act = tbop_pkg::A_COMPLETE;
							ev  = tbop_pkg::EV_I32;
							pay = {{32{w[31]}}, w};
						end
						tbop_pkg::TAG_U32: begin
							act = tbop_pkg::A_COMPLETE;
							ev  = tbop_pkg::EV_U32;
							pay = 64'(w);
						end
						tbop_pkg::TAG_LIST32: begin
							cont_req = 1'b1;
							cont_cnt = w;
						end
						default: begin
							cont_req  = 1'b1;
							cont_dict = 1'b1;
							cont_cnt  = w;
						end
					endcase
				end
			end
			tbop_pkg::PH_STRING: begin
				ev  = tbop_pkg::EV_STRBYTE;
				pay = 64'(b);
				if (str_left_q == 32'd1) act = tbop_pkg::A_COMPLETE;
				else act = tbop_pkg::A_EMIT;
			end
			default: begin
			end
		endcase

		if (str_req) begin
			ev = tbop_pkg::EV_STRSTART;
			if (str_len == '0) begin
				act = tbop_pkg::A_COMPLETE;
			end else begin
				act  = tbop_pkg::A_EMIT;
				pay  = 64'(str_len);
				ph_b = tbop_pkg::PH_STRING;
			end
		end
		if (cont_req) begin
			if (cont_cnt == '0) begin
				act = tbop_pkg::A_COMPLETE;
				ev  = cont_dict ? tbop_pkg::EV_EMPTYDICT : tbop_pkg::EV_EMPTYLIST;
			end else if (at_limit) begin
				act = tbop_pkg::A_FAIL;
				ev  = tbop_pkg::EV_TOODEEP;
			end else begin
				act  = tbop_pkg::A_PUSH;
				ev   = cont_dict ? tbop_pkg::EV_DICTOPEN : tbop_pkg::EV_LISTOPEN;
				pay  = 64'(cont_cnt);
				ph_b = tbop_pkg::PH_TAG;
			end
		end
		if (act == tbop_pkg::A_FAIL) ph_b = tbop_pkg::PH_IGNORE;
	end

	// One level of the close cascade: the finished value lands in the top container.
	assign rem_dec      = top_q.rem - 32'd1;
	assign step_done    = open_q == '0;
	assign step_key     = !step_done && top_q.dict && !top_q.key;
	assign step_pop     = !step_done && !step_key && (rem_dec == '0);
	assign run_complete = take && (act == tbop_pkg::A_COMPLETE);
	assign close_step   = (st_q == tbop_pkg::ST_CLOSE) && out_free;
	assign step_en      = run_complete || close_step;
	assign popping      = step_en && step_pop;
	assign step_stop    = step_en && !step_pop;
	assign push_now     = take && (act == tbop_pkg::A_PUSH);

	// Result item and end-of-byte bookkeeping.
	always_comb begin
		emit      = 1'b0;
		emit_res  = '0;
		emit_last = 1'b1;
		byte_end  = 1'b0;
		cur_last  = q_item.last;
		ph_after  = ph_b;
		if (step_stop) begin
			byte_end = 1'b1;
			emit     = 1'b1;
			ph_after = step_done ? tbop_pkg::PH_IGNORE : tbop_pkg::PH_TAG;
			if (run_complete) begin
				emit_res.event_res  = ev;
				emit_res.payload    = pay;
				emit_res.nest_level = open7;
				emit_res.is_key     = key_pos;
			end else begin
				cur_last            = p_last_q;
				emit_res.event_res  = p_ev_q;
				emit_res.payload    = p_pay_q;
				emit_res.nest_level = p_nest_q;
				emit_res.is_key     = p_key_q;
				emit_res.closes     = p_closes_q;
			end
			emit_res.object_done = step_done;
		end else if (take && act != tbop_pkg::A_COMPLETE) begin
			byte_end = 1'b1;
			if (act != tbop_pkg::A_NONE) begin
				emit                = 1'b1;
				emit_res.event_res  = ev;
				emit_res.payload    = pay;
				emit_res.nest_level = open7;
				emit_res.is_key     = (act == tbop_pkg::A_FAIL) ? 1'b0 : key_pos;
			end
		end else if (st_q == tbop_pkg::ST_TRUNC && out_free) begin
			emit                = 1'b1;
			emit_res.event_res  = tbop_pkg::EV_TRUNC;
			emit_res.nest_level = open7;
		end
		go_trunc = byte_end && cur_last && ph_after != tbop_pkg::PH_IGNORE;
		if (byte_end) emit_last = !go_trunc;
		do_reset = (byte_end && cur_last && !go_trunc) ||
			(st_q == tbop_pkg::ST_TRUNC && out_free);
	end

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			tbop_pkg::ST_RUN: begin
				if (popping) st_n = tbop_pkg::ST_CLOSE;
				else if (go_trunc) st_n = tbop_pkg::ST_TRUNC;
			end
			tbop_pkg::ST_CLOSE: begin
				if (step_stop) st_n = go_trunc ? tbop_pkg::ST_TRUNC : tbop_pkg::ST_RUN;
			end
			tbop_pkg::ST_TRUNC: begin
				if (out_free) st_n = tbop_pkg::ST_RUN;
			end
			default: st_n = tbop_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		open_n = open_q;
		if (do_reset) open_n = '0;
		else if (push_now) open_n = open_q + 1'b1;
		else if (popping) open_n = open_q - 1'b1;
	end

	assign wr_addr = AW'(open_q - 1'b1);
	assign rd_addr = AW'(open_n - 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= tbop_pkg::ST_RUN;
			phase_q    <= tbop_pkg::PH_TAG;
			open_q     <= '0;
			out_vld_q  <= 1'b0;
			op_left_q  <= '0;
			op_pos_q   <= '0;
			str_left_q <= '0;
			held_q     <= '0;
		end else begin
			st_q   <= st_n;
			open_q <= open_n;
			if (do_reset) phase_q <= tbop_pkg::PH_TAG;
			else if (byte_end) phase_q <= ph_after;
			if (emit) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
			if (take && start_op) begin
				held_q    <= b;
				op_left_q <= tbop_pkg::operand_size(b);
				op_pos_q  <= '0;
			end else if (take && phase_q == tbop_pkg::PH_OPERAND) begin
				op_left_q <= op_left_q - 4'd1;
				op_pos_q  <= op_pos_q + 3'd1;
			end
			if (take && str_req) str_left_q <= str_len;
			else if (take && phase_q == tbop_pkg::PH_STRING) str_left_q <= str_left_q - 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && start_op) acc_q <= '0;
		else if (take && phase_q == tbop_pkg::PH_OPERAND) acc_q <= acc_ins;

		if (push_now) begin
			top_q <= '{rem: cont_cnt, dict: cont_dict, key: 1'b0};
		end else if (popping) begin
			top_q <= rd_q;
		end else if (step_stop && !step_done) begin
			if (step_key) begin
				top_q.key <= 1'b1;
			end else begin
				top_q.rem <= rem_dec;
				top_q.key <= 1'b0;
			end
		end

		// Levels below the top live in the RAM; rd_q always holds the one just below.
		if (push_now && open_q != '0) mem[wr_addr] <= top_q;
		if (push_now) rd_q <= top_q;
		else rd_q <= mem[rd_addr];

		if (run_complete) begin
			p_ev_q     <= ev;
			p_pay_q    <= pay;
			p_nest_q   <= open7;
			p_key_q    <= key_pos;
			p_last_q   <= q_item.last;
			p_closes_q <= 7'(step_pop);
		end else if (popping) begin
			p_closes_q <= p_closes_q + 7'd1;
		end

		if (emit) begin
			out_res_q  <= emit_res;
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_res_q.object_done, out_res_q.closes, out_res_q.is_key,
		out_res_q.nest_level, out_res_q.payload};
	assign m_axis_tuser  = out_res_q.event_res;
	assign m_axis_tlast  = out_last_q;

endmodule

/* hw/rtl/tagged_binary_object_parser.sv */
// Streaming decoder for a tagged binary object format. Bytes enter on s_axis with
// tlast marking the last byte of a buffer; token events leave on m_axis with the
// event kind on tuser, tlast set on the final event a byte causes. A value that
// completes containers closes them one level at a time, because each level below
// the top is fetched from the nesting stack RAM one entry at a time. A buffer that
// ends with the object unfinished adds a truncated event. A four-item input queue
// separates intake from decoding. Every byte, even one that yields no result item,
// waits until the output register is free; the register is refilled in the same
// cycle its item is taken, so decoding halts only while a result item sits
// unaccepted, while containers are being closed or while a truncated event is pending.
module tagged_binary_object_parser #(
	parameter int MAX_NEST = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // payload, nest_level, is_key, closes, object_done
	output logic [4:0]  m_axis_tuser,   // event_res
	output logic        m_axis_tlast
);

	logic              q_valid;
	logic              q_ready;
	tbop_pkg::qitem_t  q_item;

	tbop_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item)
	);

	tbop_back #(.MAX_NEST(MAX_NEST)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

/* hw/rtl/tbop_checker.sv */
module tbop_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [4:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	logic [4:0] ev;
	logic       is_err;
	assign ev     = m_axis_tuser;
	assign is_err = ev == tbop_pkg::EV_BADTAG || ev == tbop_pkg::EV_TOODEEP ||
		ev == tbop_pkg::EV_TRUNC;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result item changed while stalled");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && is_err
		|-> m_axis_tdata[78:72] == 7'd0 && !m_axis_tdata[79] && !m_axis_tdata[71])
		else $error("error event carries closes, key or done");

	a_done_closes_all: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[79] |-> m_axis_tdata[78:72] == m_axis_tdata[70:64])
		else $error("object done without closing every open container");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ev == tbop_pkg::EV_TRUNC |-> m_axis_tlast)
		else $error("truncated event is not the last of its run");

endmodule

bind tagged_binary_object_parser tbop_checker u_tbop_checker (.*);
